/* sv/fpba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package fpba_pkg;

  // Fixed widths of the stream fields.
  localparam int VALUE_W    = 16;
  localparam int INDEX_W    = 4;
  localparam int OUT_SIZE_W = 16;
  localparam int POLICY_W   = 2;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_BLOCKS = 16;
  localparam int DEF_SIZE_BITS  = 16;

  // Allocation policies. The unused code behaves as first fit.
  localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_RESTORE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_ALLOC = 2'd1,
    STAT_NOFIT = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DRAIN,
    ST_RESP
  } state_t;

  typedef struct packed {
    cmd_t               cmd;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    status_t               status;
    logic [INDEX_W-1:0]    index;
    logic [OUT_SIZE_W-1:0] size;
  } result_t;

endpackage

`default_nettype wire

/* sv/fpba_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module fpba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* sv/fpba_front.sv */
`timescale 1ns / 1ps
`default_nettype none

// Input side: decodes the command and holds up to two transactions so that
// the sender is not stalled while the back end is busy with a sweep.
module fpba_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [fpba_pkg::VALUE_W-1:0]  in_tdata,
  input  wire logic [1:0]                    in_tuser,
  output logic                               q_valid,
  output fpba_pkg::item_t                    q_item,
  input  wire logic                          q_pop
);

  fpba_pkg::item_t q_mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      fill_r, fill_nxt;
  logic            push;
  logic            pop;
  fpba_pkg::item_t new_item;

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (fill_r != 2'd0);
  assign pop       = q_pop && q_valid;
  assign q_item    = q_mem_r[rd_ptr_r];

  always_comb begin
    new_item.cmd   = fpba_pkg::cmd_t'(in_tuser);
    new_item.value = in_tdata;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

`default_nettype wire

/* sv/fpba_back.sv */
`timescale 1ns / 1ps
`default_nettype none

// Execution side: owns the block table and walks it one entry per cycle for
// allocation and restore, then commits the command into the result register.
module fpba_back #(
  parameter int MAX_BLOCKS = fpba_pkg::DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [fpba_pkg::POLICY_W-1:0] policy,
  input  wire logic                          q_valid,
  input  wire fpba_pkg::item_t               q_item,
  output logic                               q_pop,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output fpba_pkg::result_t                  out_res
);

  localparam int AW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  fpba_pkg::state_t  state_r, state_nxt;
  fpba_pkg::cmd_t    cur_cmd_r;
  logic [SIZE_BITS-1:0] cur_val_r;
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     scan_cnt_r;
  logic              rd_vld_r;
  logic [AW-1:0]     rd_idx_r;
  logic              pick_vld_r, pick_vld_nxt;
  logic [AW-1:0]     pick_idx_r, pick_idx_nxt;
  logic [SIZE_BITS-1:0] pick_size_r, pick_size_nxt;
  logic              out_vld_r;
  fpba_pkg::result_t out_res_r;
  fpba_pkg::result_t res;

  logic              sweep_issue;
  logic              last_issue;
  logic              commit;
  logic              full;
  logic              granted;
  logic              fits;
  logic              take;

  logic [SIZE_BITS-1:0] loaded_rd;
  logic [SIZE_BITS-1:0] rem_rd;
  logic                 ld_we;
  logic                 rem_we;
  logic [AW-1:0]        rem_waddr;
  logic [SIZE_BITS-1:0] rem_wdata;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fpba_pkg::ST_IDLE: begin
        if (q_valid) begin
          if ((q_item.cmd == fpba_pkg::CMD_ALLOC || q_item.cmd == fpba_pkg::CMD_RESTORE)
              && count_r != '0) begin
            state_nxt = fpba_pkg::ST_SWEEP;
          end else begin
            state_nxt = fpba_pkg::ST_RESP;
          end
        end
      end
      fpba_pkg::ST_SWEEP: begin
        if (last_issue) begin
          state_nxt = fpba_pkg::ST_DRAIN;
        end
      end
      fpba_pkg::ST_DRAIN: begin
        state_nxt = fpba_pkg::ST_RESP;
      end
      fpba_pkg::ST_RESP: begin
        if (commit) begin
          state_nxt = fpba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpba_pkg::ST_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    q_pop       = 1'b0;
    sweep_issue = 1'b0;
    commit      = 1'b0;
    case (state_r)
      fpba_pkg::ST_IDLE:  q_pop       = q_valid;
      fpba_pkg::ST_SWEEP: sweep_issue = 1'b1;
      fpba_pkg::ST_RESP:  commit      = !out_vld_r || out_tready;
      default: begin
      end
    endcase
  end

  assign last_issue = sweep_issue && (scan_cnt_r == count_r - CW'(1));
  assign full       = (count_r >= CW'(MAX_BLOCKS));

  // Candidate selection for the entry whose read data returns this cycle.
  assign fits = (rem_rd >= cur_val_r);
  always_comb begin
    case (policy)
      fpba_pkg::POL_BEST:  take = fits && (!pick_vld_r || rem_rd < pick_size_r);
      fpba_pkg::POL_WORST: take = !pick_vld_r || rem_rd > pick_size_r;
      default:             take = fits && !pick_vld_r;
    endcase
  end

  always_comb begin
    pick_vld_nxt  = pick_vld_r;
    pick_idx_nxt  = pick_idx_r;
    pick_size_nxt = pick_size_r;
    if (q_pop) begin
      pick_vld_nxt = 1'b0;
    end else if (rd_vld_r && cur_cmd_r == fpba_pkg::CMD_ALLOC && take) begin
      pick_vld_nxt  = 1'b1;
      pick_idx_nxt  = rd_idx_r;
      pick_size_nxt = rem_rd;
    end
  end

  assign granted = pick_vld_r && (cur_val_r != '0) &&
                   (policy != fpba_pkg::POL_WORST || pick_size_r >= cur_val_r);

  // Result of the current command, valid in the response state.
  always_comb begin
    res.status = fpba_pkg::STAT_DONE;
    res.index  = '0;
    res.size   = '0;
    case (cur_cmd_r)
      fpba_pkg::CMD_LOAD: begin
        if (full) begin
          res.status = fpba_pkg::STAT_FULL;
        end else begin
          res.index = fpba_pkg::INDEX_W'(count_r);
        end
      end
      fpba_pkg::CMD_ALLOC: begin
        if (granted) begin
          res.status = fpba_pkg::STAT_ALLOC;
          res.index  = fpba_pkg::INDEX_W'(pick_idx_r);
          res.size   = fpba_pkg::OUT_SIZE_W'(pick_size_r);
        end else begin
          res.status = fpba_pkg::STAT_NOFIT;
        end
      end
      default: begin
      end
    endcase
  end

  // Table writes: load and grant at commit, restore copies from the sweep.
  always_comb begin
    ld_we     = commit && cur_cmd_r == fpba_pkg::CMD_LOAD && !full;
    rem_we    = 1'b0;
    rem_waddr = count_r[AW-1:0];
    rem_wdata = cur_val_r;
    if (rd_vld_r && cur_cmd_r == fpba_pkg::CMD_RESTORE) begin
      rem_we    = 1'b1;
      rem_waddr = rd_idx_r;
      rem_wdata = loaded_rd;
    end else if (ld_we) begin
      rem_we = 1'b1;
    end else if (commit && cur_cmd_r == fpba_pkg::CMD_ALLOC && granted) begin
      rem_we    = 1'b1;
      rem_waddr = pick_idx_r;
      rem_wdata = '0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ld_we) begin
      count_nxt = count_r + CW'(1);
    end else if (commit && cur_cmd_r == fpba_pkg::CMD_CLEAR) begin
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= fpba_pkg::ST_IDLE;
      count_r    <= '0;
      rd_vld_r   <= 1'b0;
      pick_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      rd_vld_r   <= sweep_issue;
      pick_vld_r <= pick_vld_nxt;
      if (commit) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_cmd_r  <= q_item.cmd;
      cur_val_r  <= SIZE_BITS'(q_item.value);
      scan_cnt_r <= '0;
    end else if (sweep_issue) begin
      scan_cnt_r <= scan_cnt_r + CW'(1);
    end
    rd_idx_r    <= scan_cnt_r[AW-1:0];
    pick_idx_r  <= pick_idx_nxt;
    pick_size_r <= pick_size_nxt;
    if (commit) begin
      out_res_r <= res;
    end
  end

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_loaded_ram (
    .clk     (clk),
    .wr_en   (ld_we),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (cur_val_r),
    .rd_addr (scan_cnt_r[AW-1:0]),
    .rd_data (loaded_rd)
  );

  fpba_ram #(
    .WIDTH (SIZE_BITS),
    .DEPTH (MAX_BLOCKS)
  ) u_remain_ram (
    .clk     (clk),
    .wr_en   (rem_we),
    .wr_addr (rem_waddr),
    .wr_data (rem_wdata),
    .rd_addr (scan_cnt_r[AW-1:0]),
    .rd_data (rem_rd)
  );

  assign out_tvalid = out_vld_r;
  assign out_res    = out_res_r;

`ifndef SYNTH
  // A table read returns only while a sweep is running or draining.
  a_rd_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (state_r == fpba_pkg::ST_SWEEP || state_r == fpba_pkg::ST_DRAIN))
    else $error("table read returned outside a sweep");

  // The sweep never addresses a slot beyond the loaded blocks.
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == fpba_pkg::ST_SWEEP) |-> (scan_cnt_r < count_r))
    else $error("sweep ran past the loaded blocks");

  // A granted block is always one of the loaded blocks.
  a_grant_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && cur_cmd_r == fpba_pkg::CMD_ALLOC && granted) |-> (CW'(pick_idx_r) < count_r))
    else $error("grant of an unloaded block");

  // Clearing the table empties it.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && cur_cmd_r == fpba_pkg::CMD_CLEAR) |=> (count_r == '0))
    else $error("table not empty after clear");
`endif

endmodule

`default_nettype wire

/* sv/fit_policy_block_allocator.sv */
// Fit-policy block allocator.
// Commands arrive on the in_ stream: in_tuser carries the command (load a
// block size, allocate a request, restore all blocks, clear the table) and
// in_tdata the size. Each command returns exactly one transaction on the out_
// stream with a status in out_tuser and the block index and size in out_tdata.
// The policy register (first, best or worst fit) is written through cfg_wr_en and
// cfg_wr_data only while no command is in flight, a rule for the user that the block does not enforce.
// Load and clear go from idle straight to the response state. Allocate and
// restore first pass through a sweep over the N loaded blocks and a drain state,
// because the table is walked one entry per cycle through a registered RAM
// read; with no blocks loaded they go straight to the response state as well.
// A two-entry queue sits between the input side and the execution unit, so
// up to two further commands are taken while one is being worked on. The
// result sits in an output register; when the receiver holds out_tready low
// the unit waits with the next result until the register is free.
// Reset empties the queue and the table and sets the policy to first fit.
`timescale 1ns / 1ps
`default_nettype none

module fit_policy_block_allocator #(
  parameter int MAX_BLOCKS = fpba_pkg::DEF_MAX_BLOCKS,
  parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [15:0] size_value
  input  wire logic [1:0]  in_tuser,    // [1:0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,   // [3:0] block_index, [19:4] block_size, rest zero
  output logic [1:0]       out_tuser,   // [1:0] status
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_wr_data  // [1:0] fit_policy
);

  // Policy register; the user must write it only while the unit is idle; the block does not enforce it.
  logic [fpba_pkg::POLICY_W-1:0] policy_r;

  fpba_pkg::item_t   q_item;
  logic              q_valid;
  logic              q_pop;
  fpba_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= fpba_pkg::POL_FIRST;
    end else if (cfg_wr_en) begin
      policy_r <= cfg_wr_data;
    end
  end

  fpba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  fpba_back #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .policy     (policy_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (res)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {4'b0000, res.size, res.index};
  assign out_tuser = res.status;

endmodule

`default_nettype wire
